FILE: design/ecgbq_pkg.sv
// ============================================================================
// ecgbq_pkg
// Shared types and constants for the ECG biquad cascade filter: section and
// term counts, digit size of the serial multiplier, coefficient table and
// controller states.
// ============================================================================
package ecgbq_pkg;

  localparam int NUM_SECT   = 3;
  localparam int NUM_TERM   = 5;
  localparam int NUM_PROD   = NUM_SECT * NUM_TERM;
  localparam int DIGIT_BITS = 4;
  localparam int STATE_FRAC = 16;

  // Per section, in millionths, in evaluation order: -a1, -a2, b0, b1, b2
  localparam int COEF_MICRO [NUM_PROD] = '{
    1991114, -991154, 995567, -1991134, 995567,
    1307285, -491812, 46132, 92264, 46132,
    1603639, -982207, 991104, -1603639, 991104
  };

  typedef enum logic [2:0] {
    TERM_FB1,
    TERM_FB2,
    TERM_FF0,
    TERM_FF1,
    TERM_FF2
  } term_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_ROUND,
    ST_ACC,
    ST_OUT
  } state_t;

endpackage

FILE: design/ecg_biquad_cascade_filter.sv
// Scheduling: a filter sample runs through all 15 coefficient products (NDIG =
// coefficient digits of 4 bits) on the single shared 4-bit digit-serial
// multiplier, and no new input is taken until its result is registered. A
// clear transfer zeroes the delay words and leaves the input ready.
// Reset: synchronous, active low; zeroes all six delay words and drops
// out_tvalid.
// ============================================================================
// ecg_biquad_cascade_filter
// Three direct form II biquads (high-pass, low-pass, notch) in fixed point,
// evaluated through one digit-serial multiply-accumulate unit.
// ============================================================================
module ecg_biquad_cascade_filter
  import ecgbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 24,
  parameter int STATE_WIDTH    = 48
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,   // sample_in
  input  logic [0:0]                            in_tuser,   // [0] action
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata,  // sample_out
  output logic [0:0]                            out_tuser   // [0] saturated
);

  localparam int SW   = STATE_WIDTH;
  localparam int DW   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int CMW  = COEF_FRAC_BITS + 2;
  localparam int NDIG = (CMW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NL   = NDIG * DIGIT_BITS;
  localparam int HW   = SW + DIGIT_BITS;
  localparam int PW   = SW + NL;
  localparam int RW   = PW + 1 - COEF_FRAC_BITS;
  localparam int OW   = SW + 1 - STATE_FRAC;
  localparam int DCW  = $clog2(NDIG);
  localparam int IW   = $clog2(NUM_PROD);

  // coefficient table, Q2.COEF_FRAC_BITS sign-magnitude
  logic [CMW-1:0]      coef_mag_tab [NUM_PROD];
  logic [NUM_PROD-1:0] coef_neg_tab;

  for (genvar gi = 0; gi < NUM_PROD; gi++) begin : g_coef
    localparam longint MICRO_MAG = (COEF_MICRO[gi] < 0) ? longint'(-COEF_MICRO[gi])
                                                        : longint'(COEF_MICRO[gi]);
    localparam longint COEF_Q = ((MICRO_MAG <<< COEF_FRAC_BITS) + 64'sd500000)
                                / 64'sd1000000;
    assign coef_mag_tab[gi] = CMW'(COEF_Q);
    assign coef_neg_tab[gi] = (COEF_MICRO[gi] < 0);
  end

  state_t                  state_r, state_nxt;
  term_t                   term_r, term_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [DCW-1:0]          dig_r, dig_nxt;
  logic signed [SW-1:0]    acc_r, acc_nxt;
  logic signed [SW-1:0]    w_r, w_nxt;
  logic signed [SW-1:0]    d0_r [NUM_SECT];
  logic signed [SW-1:0]    d0_nxt [NUM_SECT];
  logic signed [SW-1:0]    d1_r [NUM_SECT];
  logic signed [SW-1:0]    d1_nxt [NUM_SECT];
  logic [SW-1:0]           mcand_r, mcand_nxt;
  logic                    neg_r, neg_nxt;
  logic [SW-1:0]           hi_r, hi_nxt;
  logic [NL-1:0]           lo_r, lo_nxt;
  logic [RW-1:0]           rnd_r, rnd_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic                    out_sat_r, out_sat_nxt;

  logic signed [SW-1:0]    sel_val;
  logic [SW-1:0]           sel_mag;
  logic [HW-1:0]           mac_sum;
  logic [PW:0]             round_sum;
  logic [RW-1:0]           lim;
  logic [SW-1:0]           mag_clip;
  logic signed [SW-1:0]    prod_val;
  logic [SW:0]             sum_ext;
  logic signed [SW-1:0]    add_res;
  logic                    y_neg;
  logic [SW-1:0]           y_mag;
  logic [SW:0]             y_round;
  logic [OW-1:0]           y_int;
  logic [OW-1:0]           pos_lim;
  logic [OW-1:0]           neg_lim;
  logic                    clip;
  logic [SAMPLE_WIDTH-1:0] m_clip;
  logic [SAMPLE_WIDTH-1:0] out_val;

  // datapath
  always_comb begin
    unique case (term_r)
      TERM_FB1, TERM_FF1: sel_val = d0_r[0];
      TERM_FB2, TERM_FF2: sel_val = d1_r[0];
      TERM_FF0:           sel_val = w_r;
      default:            sel_val = w_r;
    endcase
    sel_mag = sel_val[SW-1] ? SW'(-sel_val) : SW'(sel_val);

    mac_sum   = HW'(hi_r) + HW'(mcand_r) * HW'(lo_r[DIGIT_BITS-1:0]);
    round_sum = (PW+1)'({hi_r, lo_r}) + ((PW+1)'(1) << (COEF_FRAC_BITS - 1));

    lim      = RW'({1'b0, {(SW-1){1'b1}}}) + RW'(neg_r);
    mag_clip = (rnd_r > lim) ? SW'(lim) : SW'(rnd_r);
    prod_val = neg_r ? -$signed(mag_clip) : $signed(mag_clip);
    sum_ext  = {acc_r[SW-1], acc_r} + {prod_val[SW-1], prod_val};
    if (sum_ext[SW] != sum_ext[SW-1]) begin
      add_res = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      add_res = sum_ext[SW-1:0];
    end

    y_neg   = acc_r[SW-1];
    y_mag   = y_neg ? SW'(-acc_r) : SW'(acc_r);
    y_round = {1'b0, y_mag} + ((SW+1)'(1) << (STATE_FRAC - 1));
    y_int   = y_round[SW:STATE_FRAC];
    pos_lim = OW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    neg_lim = pos_lim + OW'(1);
    clip    = y_neg ? (y_int > neg_lim) : (y_int > pos_lim);
    if (clip) begin
      m_clip = y_neg ? SAMPLE_WIDTH'(neg_lim) : SAMPLE_WIDTH'(pos_lim);
    end else begin
      m_clip = SAMPLE_WIDTH'(y_int);
    end
    out_val = y_neg ? SAMPLE_WIDTH'(-m_clip) : m_clip;
  end

  // controller
  always_comb begin
    state_nxt      = state_r;
    term_nxt       = term_r;
    idx_nxt        = idx_r;
    dig_nxt        = dig_r;
    acc_nxt        = acc_r;
    w_nxt          = w_r;
    d0_nxt         = d0_r;
    d1_nxt         = d1_r;
    mcand_nxt      = mcand_r;
    neg_nxt        = neg_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    rnd_nxt        = rnd_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_sat_nxt    = out_sat_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0]) begin
            for (int i = 0; i < NUM_SECT; i++) begin
              d0_nxt[i] = '0;
              d1_nxt[i] = '0;
            end
          end else begin
            acc_nxt   = SW'($signed({in_tdata[SAMPLE_WIDTH-1:0], {STATE_FRAC{1'b0}}}));
            idx_nxt   = '0;
            term_nxt  = TERM_FB1;
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        mcand_nxt = sel_mag;
        neg_nxt   = sel_val[SW-1] ^ coef_neg_tab[idx_r];
        hi_nxt    = '0;
        lo_nxt    = NL'(coef_mag_tab[idx_r]);
        dig_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        hi_nxt  = mac_sum[HW-1:DIGIT_BITS];
        lo_nxt  = {mac_sum[DIGIT_BITS-1:0], lo_r[NL-1:DIGIT_BITS]};
        dig_nxt = DCW'(dig_r + 1'b1);
        if (dig_r == DCW'(NDIG - 1)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rnd_nxt   = round_sum[PW:COEF_FRAC_BITS];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = add_res;
        unique case (term_r)
          TERM_FB1: term_nxt = TERM_FB2;
          TERM_FB2: begin
            w_nxt    = add_res;
            acc_nxt  = '0;
            term_nxt = TERM_FF0;
          end
          TERM_FF0: term_nxt = TERM_FF1;
          TERM_FF1: term_nxt = TERM_FF2;
          TERM_FF2: begin
            // rotate the section ring; the updated pair goes to the tail
            for (int i = 0; i < NUM_SECT - 1; i++) begin
              d0_nxt[i] = d0_r[i+1];
              d1_nxt[i] = d1_r[i+1];
            end
            d0_nxt[NUM_SECT-1] = w_r;
            d1_nxt[NUM_SECT-1] = d0_r[0];
            term_nxt = TERM_FB1;
          end
          default: term_nxt = TERM_FB1;
        endcase
        idx_nxt   = IW'(idx_r + 1'b1);
        state_nxt = (idx_r == IW'(NUM_PROD - 1)) ? ST_OUT : ST_SETUP;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = out_val;
          out_sat_nxt    = clip;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SECT; i++) begin
        d0_r[i] <= '0;
        d1_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      d0_r        <= d0_nxt;
      d1_r        <= d1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    term_r       <= term_nxt;
    idx_r        <= idx_nxt;
    dig_r        <= dig_nxt;
    acc_r        <= acc_nxt;
    w_r          <= w_nxt;
    mcand_r      <= mcand_nxt;
    neg_r        <= neg_nxt;
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    rnd_r        <= rnd_nxt;
    out_sample_r <= out_sample_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'(out_sample_r);
  assign out_tuser  = out_sat_r;

endmodule

FILE: design/ecgbq_checker.sv
// ============================================================================
// ecgbq_checker
// Port-level checks for the ECG biquad cascade filter, bound to the top level.
// ============================================================================
module ecgbq_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [0:0]                        in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [0:0]                        out_tuser
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a filter transfer occupies the datapath, a clear does not
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> !in_tready)
    else $error("input taken while a sample is in flight");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> in_tready && !$rose(out_tvalid))
    else $error("clear transfer produced work");

  // clip flag only with a full-scale value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[SAMPLE_WIDTH-1:0] == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} ||
      out_tdata[SAMPLE_WIDTH-1:0] == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})
    else $error("saturated flag without full-scale output");

endmodule

bind ecg_biquad_cascade_filter ecgbq_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_ecgbq_checker (.*);

FILE: tb/sv/testbench.sv
// ============================================================================
// testbench: ECG biquad cascade filter
// Streams samples and clear transfers into the three-section biquad cascade.
// An in-bench fixed-point model of the cascade predicts each output sample
// and its clip flag. A monitor compares every output transfer, field by
// field, against the oldest prediction. Stimulus covers sample extremes,
// output clipping, clears, and random traffic under four idle/stall mixes.
// ============================================================================
module testbench;

  typedef logic signed [95:0] acc_t;

  typedef enum bit {
    ACT_FILTER = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_t;

  typedef enum int {
    K_B0,
    K_B1,
    K_B2,
    K_FB1,
    K_FB2
  } coef_idx_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               saturated;
  } filt_result_t;

  localparam acc_t WORD_MAX       = (acc_t'(1) <<< 47) - 1;
  localparam acc_t WORD_MIN       = -(acc_t'(1) <<< 47);
  localparam acc_t PROD_HALF      = acc_t'(1) <<< 23;
  localparam int   COEF_SHIFT     = 24;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   DRAIN_CYCLES   = 200;
  localparam int   MAX_REPORTS    = 30;

  // millionths per section: b0, b1, b2, -a1, -a2
  localparam int BIQUAD_MICRO [3][5] = '{
    '{995567, -1991134, 995567, 1991114, -991154},
    '{46132, 92264, 46132, 1307285, -491812},
    '{991104, -1603639, 991104, 1603639, -982207}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  acc_t         sect_w [3][2];
  filt_result_t pending_outputs [$];
  filt_result_t got_exp;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           n_errors       = 0;
  int           n_filtered     = 0;
  int           n_clears       = 0;
  int           n_clipped      = 0;
  int           quiet_cycles   = 0;

  ecg_biquad_cascade_filter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < 3; k++) begin
      sect_w[k][0] = '0;
      sect_w[k][1] = '0;
    end
  end

  function automatic acc_t clamp_word(acc_t v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic acc_t q_coef(int micro);
    longint m;
    m = (micro < 0) ? -longint'(micro) : longint'(micro);
    m = ((m <<< COEF_SHIFT) + 500000) / 1000000;
    return (micro < 0) ? -acc_t'(m) : acc_t'(m);
  endfunction

  // Q2.24 times Q.16, rounded half away from zero back to Q.16
  function automatic acc_t scale_product(int micro, acc_t w);
    acc_t p;
    acc_t m;
    p = q_coef(micro) * w;
    m = (p < 0) ? -p : p;
    m = (m + PROD_HALF) >>> COEF_SHIFT;
    return clamp_word((p < 0) ? -m : m);
  endfunction

  function automatic filt_result_t cascade_predict(logic signed [15:0] s);
    acc_t         x;
    acc_t         w;
    acc_t         y;
    acc_t         m;
    filt_result_t res;
    x = acc_t'(s) <<< 16;
    for (int k = 0; k < 3; k++) begin
      w = clamp_word(x + scale_product(BIQUAD_MICRO[k][K_FB1], sect_w[k][0]));
      w = clamp_word(w + scale_product(BIQUAD_MICRO[k][K_FB2], sect_w[k][1]));
      y = clamp_word(scale_product(BIQUAD_MICRO[k][K_B0], w) +
                     scale_product(BIQUAD_MICRO[k][K_B1], sect_w[k][0]));
      y = clamp_word(y + scale_product(BIQUAD_MICRO[k][K_B2], sect_w[k][1]));
      sect_w[k][1] = sect_w[k][0];
      sect_w[k][0] = w;
      x = y;
    end
    m = (x < 0) ? -x : x;
    m = (m + 32768) >>> 16;
    res.saturated = 1'b0;
    if (x < 0) begin
      if (m > 32768) begin
        m = 32768;
        res.saturated = 1'b1;
      end
      m = -m;
    end else if (m > 32767) begin
      m = 32767;
      res.saturated = 1'b1;
    end
    res.sample_out = m[15:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
  endtask

  task automatic send_item(action_t act, logic signed [15:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= s;
    in_tuser[0] <= act;
    do @(posedge clk); while (!in_tready);
    if (act == ACT_CLEAR) begin
      for (int k = 0; k < 3; k++) begin
        sect_w[k][0] = '0;
        sect_w[k][1] = '0;
      end
      n_clears++;
    end else begin
      pending_outputs.push_back(cascade_predict(s));
      n_filtered++;
    end
  endtask

  task automatic test_sample_extremes();
    send_item(ACT_FILTER, 16'sd0);
    send_item(ACT_FILTER, 16'sd1);
    send_item(ACT_FILTER, -16'sd1);
    send_item(ACT_FILTER, 16'sd32767);
    send_item(ACT_FILTER, -16'sd32768);
  endtask

  // full-scale steps overshoot past the 16-bit range on both rails
  task automatic test_output_clipping();
    repeat (5) send_item(ACT_FILTER, -16'sd32768);
    repeat (5) send_item(ACT_FILTER, 16'sd32767);
    repeat (5) send_item(ACT_FILTER, -16'sd32768);
  endtask

  // clear ignores the sample field; back-to-back clears; state is zero after
  task automatic test_clear();
    send_item(ACT_CLEAR, 16'sh7A5C);
    send_item(ACT_FILTER, 16'sd32767);
    send_item(ACT_CLEAR, -16'sd32768);
    send_item(ACT_CLEAR, 16'sd0);
    send_item(ACT_FILTER, -16'sd32768);
  endtask

  task automatic test_random_stream(int n_items, int idle_pct, int stall_pct);
    int                 sent;
    int                 kind;
    int                 len;
    logic signed [15:0] s;
    logic               rail_high;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent           = 0;
    rail_high      = 1'b0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 4) begin
        s = 16'($urandom);
        send_item(ACT_CLEAR, s);
        sent++;
      end else if (kind < 14) begin
        rail_high = ~rail_high;
        len = $urandom_range(8, 4);
        repeat (len) send_item(ACT_FILTER, rail_high ? 16'sd32767 : -16'sd32768);
        sent += len;
      end else if (kind < 35) begin
        s = 16'($urandom_range(2000)) - 16'sd1000;
        send_item(ACT_FILTER, s);
        sent++;
      end else begin
        s = 16'($urandom);
        send_item(ACT_FILTER, s);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected output transfer", 0, $signed(out_tdata));
      end else begin
        got_exp = pending_outputs.pop_front();
        if (got_exp.saturated) n_clipped++;
        if (out_tdata !== got_exp.sample_out)
          report_mismatch("sample_out", got_exp.sample_out, $signed(out_tdata));
        if (out_tuser[0] !== got_exp.saturated)
          report_mismatch("saturated", got_exp.saturated, out_tuser[0]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("[ecg_biquad_cascade_filter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sample_extremes();
    test_output_clipping();
    test_clear();
    test_random_stream(140, 0, 0);
    test_random_stream(140, 83, 0);
    test_random_stream(140, 0, 83);
    test_random_stream(130, 18, 18);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d filtered samples and %0d clears, %0d outputs clipped",
             n_filtered, n_clears, n_clipped);
    $display("traffic: no gaps, sender gaps, receiver stalls, and both mixed");
    if (n_errors == 0) begin
      $display("[ecg_biquad_cascade_filter] OK");
    end else begin
      $display("[ecg_biquad_cascade_filter] ERROR");
    end
    $finish;
  end

endmodule
